// File: design/vdh_pkg.sv
package vdh_pkg;

    localparam int BUCKETS  = 256;
    localparam int CAPACITY = 4096;

    localparam int BW = $clog2(BUCKETS);       // bucket select bits
    localparam int IW = $clog2(CAPACITY);      // entry index bits
    localparam int CW = $clog2(CAPACITY + 1);  // entry count bits
    localparam int KW = 16;                    // key field width
    localparam int VW = 12;                    // vertex number width

    typedef struct packed {
        logic          cmd;
        logic [KW-1:0] position_index;
        logic [KW-1:0] texcoord_index;
    } t_in_item;

    typedef struct packed {
        logic [VW-1:0] vertex_number;
        logic          is_new;
        logic          table_full;
    } t_out_item;

    typedef struct packed {
        logic [KW-1:0] pos;
        logic [KW-1:0] tex;
        logic          link_ok;
        logic [IW-1:0] link;
    } t_entry;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

endpackage

// File: design/vdh_ram.sv
module vdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/vertex_dedup_hash_table.sv
// Channel   Direction  Handshake                      Payload
// command   in         start high, busy low           i_item   (vdh_pkg::t_in_item)
// result    out        o_result_valid, one cycle      o_result (vdh_pkg::t_out_item)
//
// A clear's result is strobed in the next cycle and busy stays low.
// A lookup passes S_HEAD, then S_ENTRY for each chain entry read (one read per cycle
// through the single read port of the entry memory), then S_INSERT when the pair is not
// found, for a head insert or a full table, plus S_LINK when the new entry is linked
// behind an existing one; the result is strobed in the first cycle with busy low, and
// the next command can transfer in that same cycle.
// Reset clears the bucket valid flags and the entry count at once; no clearing pass.
// The receiver cannot stall: every result is shown for exactly one cycle.
module vertex_dedup_hash_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  vdh_pkg::t_in_item  i_item,
    output logic               o_result_valid,
    output vdh_pkg::t_out_item o_result
);
    import vdh_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_HEAD   = 5'b00010,
        S_ENTRY  = 5'b00100,
        S_INSERT = 5'b01000,
        S_LINK   = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [BUCKETS-1:0] r_head_ok, n_head_ok;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_steps, n_steps;
    logic [KW-1:0]     r_pos, n_pos;
    logic [KW-1:0]     r_tex, n_tex;
    logic              r_cur_ok, n_cur_ok;
    logic [IW-1:0]     r_cur, n_cur;
    logic              r_prev_ok, n_prev_ok;
    logic [IW-1:0]     r_prev, n_prev;
    logic [KW-1:0]     r_prev_pos, n_prev_pos;
    logic [KW-1:0]     r_prev_tex, n_prev_tex;
    logic              r_res_valid, n_res_valid;
    t_out_item         r_result, n_result;

    // memory ports
    logic              head_we;
    logic [BW-1:0]     head_raddr;
    logic [IW-1:0]     head_rd;
    logic              entry_we;
    logic [IW-1:0]     entry_waddr;
    t_entry            entry_wdata;
    logic [IW-1:0]     entry_raddr;
    t_entry            entry_rd;

    logic [BW-1:0]     bucket;
    logic [IW-1:0]     new_idx;
    logic              table_is_full;
    logic              key_eq;
    logic              key_gt;
    logic [CW-1:0]     steps_inc;

    vdh_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (bucket),
        .i_wdata (new_idx),
        .i_raddr (head_raddr),
        .o_rdata (head_rd)
    );

    vdh_ram #(.WIDTH($bits(t_entry)), .DEPTH(CAPACITY)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (entry_we),
        .i_waddr (entry_waddr),
        .i_wdata (entry_wdata),
        .i_raddr (entry_raddr),
        .o_rdata (entry_rd)
    );

    assign bucket        = r_pos[BW-1:0];
    assign new_idx       = r_count[IW-1:0];
    assign table_is_full = (r_count >= CW'(CAPACITY));
    assign steps_inc     = CW'(r_steps + CW'(1));

    // shared key comparator: stored entry against the pair being looked up
    assign key_eq = ({entry_rd.pos, entry_rd.tex} == {r_pos, r_tex});
    assign key_gt = ({entry_rd.pos, entry_rd.tex} >  {r_pos, r_tex});

    always_comb begin
        n_state     = r_state;
        n_head_ok   = r_head_ok;
        n_count     = r_count;
        n_steps     = r_steps;
        n_pos       = r_pos;
        n_tex       = r_tex;
        n_cur_ok    = r_cur_ok;
        n_cur       = r_cur;
        n_prev_ok   = r_prev_ok;
        n_prev      = r_prev;
        n_prev_pos  = r_prev_pos;
        n_prev_tex  = r_prev_tex;
        n_res_valid = 1'b0;
        n_result    = r_result;
        head_we     = 1'b0;
        head_raddr  = i_item.position_index[BW-1:0];
        entry_we    = 1'b0;
        entry_waddr = new_idx;
        entry_wdata = '{pos: r_pos, tex: r_tex, link_ok: r_cur_ok, link: r_cur};
        entry_raddr = r_cur;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pos = i_item.position_index;
                    n_tex = i_item.texcoord_index;
                    if (i_item.cmd == CMD_CLEAR) begin
                        // drop every chain at once; entries become unreachable
                        n_head_ok   = '0;
                        n_count     = '0;
                        n_result    = '0;
                        n_res_valid = 1'b1;
                    end else begin
                        // head memory read issued with the bucket of the new pair
                        n_steps   = '0;
                        n_prev_ok = 1'b0;
                        n_state   = S_HEAD;
                    end
                end
            end

            S_HEAD: begin
                n_cur_ok = r_head_ok[bucket];
                n_cur    = head_rd;
                if (r_head_ok[bucket] && (CW'(head_rd) < CW'(CAPACITY))) begin
                    entry_raddr = head_rd;
                    n_state     = S_ENTRY;
                end else begin
                    n_state = S_INSERT;
                end
            end

            S_ENTRY: begin
                if (key_eq) begin
                    n_result    = '{vertex_number: VW'(r_cur), is_new: 1'b0, table_full: 1'b0};
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (!key_gt) begin
                    // smaller key: new entry goes ahead of the current one
                    n_state = S_INSERT;
                end else begin
                    // advance along the chain, remember the entry behind the gap
                    n_prev_ok  = 1'b1;
                    n_prev     = r_cur;
                    n_prev_pos = entry_rd.pos;
                    n_prev_tex = entry_rd.tex;
                    n_cur_ok   = entry_rd.link_ok;
                    n_cur      = entry_rd.link;
                    n_steps    = steps_inc;
                    if (entry_rd.link_ok && (CW'(entry_rd.link) < CW'(CAPACITY))
                        && (steps_inc < CW'(CAPACITY))) begin
                        entry_raddr = entry_rd.link;
                    end else begin
                        n_state = S_INSERT;
                    end
                end
            end

            S_INSERT: begin
                if (table_is_full) begin
                    n_result    = '{vertex_number: '0, is_new: 1'b0, table_full: 1'b1};
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    // new entry inherits the link that pointed at the current entry
                    entry_we = 1'b1;
                    if (!r_prev_ok) begin
                        head_we           = 1'b1;
                        n_head_ok[bucket] = 1'b1;
                        n_count           = CW'(r_count + CW'(1));
                        n_result    = '{vertex_number: VW'(new_idx), is_new: 1'b1,
                                        table_full: 1'b0};
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_LINK;
                    end
                end
            end

            S_LINK: begin
                // point the previous entry at the new one
                entry_we    = 1'b1;
                entry_waddr = r_prev;
                entry_wdata = '{pos: r_prev_pos, tex: r_prev_tex, link_ok: 1'b1,
                                link: new_idx};
                n_count     = CW'(r_count + CW'(1));
                n_result    = '{vertex_number: VW'(new_idx), is_new: 1'b1, table_full: 1'b0};
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head_ok   <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head_ok   <= n_head_ok;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_steps    <= n_steps;
        r_pos      <= n_pos;
        r_tex      <= n_tex;
        r_cur_ok   <= n_cur_ok;
        r_cur      <= n_cur;
        r_prev_ok  <= n_prev_ok;
        r_prev     <= n_prev;
        r_prev_pos <= n_prev_pos;
        r_prev_tex <= n_prev_tex;
        r_result   <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

endmodule

// File: design/vdh_checker.sv
module vdh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input vdh_pkg::t_in_item  i_item,
    input logic               o_result_valid,
    input vdh_pkg::t_out_item o_result
);
    import vdh_pkg::*;

    // a clear transfer answers in the next cycle with an all-zero result
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_CLEAR) |=> (o_result_valid && o_result == '0))
        else $error("clear did not return a zero result in the next cycle");

    // a lookup transfer holds the block busy in the next cycle
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_LOOKUP) |=> busy)
        else $error("lookup accepted without going busy");

    // no result while a lookup is still walking
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> !o_result_valid)
        else $error("result strobed in the middle of a lookup");

    // full table reports number zero and no insert
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.table_full) |->
            (o_result.vertex_number == '0 && !o_result.is_new))
        else $error("table_full result with insert or nonzero number");

endmodule

bind vertex_dedup_hash_table vdh_checker u_vdh_checker (.*);

// File: tb/tb_vertex_dedup_hash_table.sv
`timescale 1ns / 100ps

module tb_vertex_dedup_hash_table;

    import vdh_pkg::*;

    // Cycles with no transfer on either side before the run is declared hung.
    // The longest walk in this stimulus is a few dozen entries and sender gaps
    // come from pick_gap, so this is many times the slowest correct case.
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_CMDS = 2000;

    typedef struct {
        t_in_item item;
        bit       drain;    // hold this command until every result is in
    } cmd_req_t;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_result_valid;
    t_out_item o_result;

    vertex_dedup_hash_table DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the interning table: bucket heads, entry store, fill count
    // ------------------------------------------------------------------
    bit          bk_ok [BUCKETS];
    bit [IW-1:0] bk_at [BUCKETS];
    t_entry      slots [CAPACITY];
    int unsigned n_used;

    cmd_req_t    cmd_backlog[$];       // commands not yet handed to the block
    t_out_item   vertex_results_due[$]; // results owed, oldest first
    bit          cmd_taken;             // command transfer at the last rising edge
    int          gap_left;
    int          calm_left;
    int          mismatch_count;
    int          idle_cycles;

    // Keys issued since the last clear, for repeat lookups.
    bit [KW-1:0] seen_p[$];
    bit [KW-1:0] seen_t[$];

    // Walk the bucket chain for one command, update the shadow and return
    // the result the block must produce.
    function automatic t_out_item intern_pair(t_in_item it);
        t_out_item   res;
        int unsigned b, cur, prev, steps, idx;
        bit          cur_ok, prev_ok;
        t_entry      e;
        res = '0;
        if (it.cmd == CMD_CLEAR) begin
            foreach (bk_ok[i]) bk_ok[i] = 1'b0;
            n_used = 0;
            return res;
        end
        b       = it.position_index % BUCKETS;
        cur_ok  = bk_ok[b];
        cur     = bk_at[b];
        prev_ok = 1'b0;
        prev    = 0;
        steps   = 0;
        // Chains are in descending key order: position first, then texcoord.
        while (cur_ok && cur < CAPACITY && steps < CAPACITY) begin
            e = slots[cur];
            if ({e.pos, e.tex} == {it.position_index, it.texcoord_index}) begin
                res.vertex_number = cur[VW-1:0];
                return res;
            end
            if ({e.pos, e.tex} < {it.position_index, it.texcoord_index}) break;
            prev_ok = 1'b1;
            prev    = cur;
            cur_ok  = e.link_ok;
            cur     = e.link;
            steps++;
        end
        if (n_used >= CAPACITY) begin
            res.table_full = 1'b1;
            return res;
        end
        idx            = n_used;
        slots[idx].pos = it.position_index;
        slots[idx].tex = it.texcoord_index;
        if (!prev_ok) begin
            // New head: the old chain hangs behind it.
            slots[idx].link_ok = bk_ok[b];
            slots[idx].link    = bk_at[b];
            bk_ok[b]           = 1'b1;
            bk_at[b]           = idx[IW-1:0];
        end else begin
            slots[idx].link_ok  = slots[prev].link_ok;
            slots[idx].link     = slots[prev].link;
            slots[prev].link_ok = 1'b1;
            slots[prev].link    = idx[IW-1:0];
        end
        n_used++;
        res.vertex_number = idx[VW-1:0];
        res.is_new        = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_pair(bit [KW-1:0] p, bit [KW-1:0] t, bit drain);
        cmd_req_t c;
        c.item.cmd            = CMD_LOOKUP;
        c.item.position_index = p;
        c.item.texcoord_index = t;
        c.drain               = drain;
        cmd_backlog.push_back(c);
        seen_p.push_back(p);
        seen_t.push_back(t);
    endtask

    // Pair fields carry random junk on a clear; the block must ignore them.
    task automatic push_clear(bit drain);
        cmd_req_t c;
        c.item.cmd            = CMD_CLEAR;
        c.item.position_index = KW'($urandom);
        c.item.texcoord_index = KW'($urandom);
        c.drain               = drain;
        cmd_backlog.push_back(c);
        seen_p.delete();
        seen_t.delete();
    endtask

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge, one command per transfer
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !cmd_taken) begin
            // hold the command until the block takes it
        end else begin
            if (start) gap_left = pick_gap();
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_backlog.size() != 0 &&
                         (!cmd_backlog[0].drain || vertex_results_due.size() == 0)) begin
                i_item <= cmd_backlog[0].item;
                void'(cmd_backlog.pop_front());
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, check results before logging
    // the command taken at the same edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        cmd_taken = i_rst_n && start && !busy;
        if (i_rst_n && o_result_valid) begin
            if (vertex_results_due.size() == 0) begin
                report_mismatch($sformatf("result with none owed: vertex %0d new %0b full %0b",
                                o_result.vertex_number, o_result.is_new, o_result.table_full));
            end else begin
                want = vertex_results_due.pop_front();
                if (o_result.vertex_number !== want.vertex_number)
                    report_mismatch($sformatf("vertex_number got %0d want %0d",
                                    o_result.vertex_number, want.vertex_number));
                if (o_result.is_new !== want.is_new)
                    report_mismatch($sformatf("is_new got %0b want %0b",
                                    o_result.is_new, want.is_new));
                if (o_result.table_full !== want.table_full)
                    report_mismatch($sformatf("table_full got %0b want %0b",
                                    o_result.table_full, want.table_full));
            end
        end
        if (cmd_taken) vertex_results_due.push_back(intern_pair(i_item));
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        bit [KW-1:0] p;
        bit [BW-1:0] hot_buckets[4];
        int          perm[CAPACITY];
        int          r, k, tmp;
        bit          drain;

        gap_left       = 0;
        calm_left      = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        cmd_taken      = 1'b0;
        n_used         = 0;
        foreach (bk_ok[i]) begin
            bk_ok[i] = 1'b0;
            bk_at[i] = '0;
        end

        // Directed: chain ordering, head/middle/tail inserts, repeats, clear.
        push_clear(1'b0);
        push_pair(16'h0000, 16'h0000, 1'b0);
        push_pair(16'hFFFF, 16'hFFFF, 1'b0);
        push_pair(16'hFFFF, 16'h0000, 1'b0);   // tail of bucket 255
        push_pair(16'hFFFF, 16'hFFFF, 1'b0);   // found
        push_pair(16'h0100, 16'h0005, 1'b0);   // head insert, old chain kept
        push_pair(16'h0000, 16'h0000, 1'b0);   // old chain still reachable
        push_pair(16'h0200, 16'h0000, 1'b0);   // head again
        push_pair(16'h0100, 16'h0003, 1'b0);   // middle, ordered by texcoord
        push_pair(16'h0100, 16'hFFFF, 1'b0);
        push_pair(16'h0000, 16'h0000, 1'b0);
        push_pair(16'h0100, 16'h0003, 1'b0);
        push_pair(16'h00FF, 16'h8000, 1'b0);   // below all keys of bucket 255
        push_pair(16'hFFFF, 16'h0000, 1'b0);
        push_pair(16'h7F80, 16'h1234, 1'b0);
        push_clear(1'b1);
        push_pair(16'hFFFF, 16'hFFFF, 1'b0);   // numbering restarts at zero
        push_pair(16'h0000, 16'h0000, 1'b0);
        push_pair(16'h0000, 16'hFFFF, 1'b0);

        // Random: repeats, same position with new texcoord, crowded buckets.
        hot_buckets = '{8'h00, 8'hFF, 8'h5A, 8'h81};
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            r     = $urandom_range(0, 99);
            drain = (n % 400 == 399);
            if (r < 2) begin
                push_clear(drain);
            end else if (r < 40 && seen_p.size() != 0) begin
                k = $urandom_range(0, seen_p.size() - 1);
                push_pair(seen_p[k], seen_t[k], drain);
            end else if (r < 60 && seen_p.size() != 0) begin
                k = $urandom_range(0, seen_p.size() - 1);
                push_pair(seen_p[k], KW'($urandom), drain);
            end else if (r < 85) begin
                p         = KW'($urandom);
                p[BW-1:0] = hot_buckets[$urandom_range(0, 3)];
                push_pair(p, KW'($urandom), drain);
            end else begin
                push_pair(KW'($urandom), KW'($urandom), drain);
            end
        end

        // Fill the table with distinct keys in shuffled order, then probe it full.
        for (int j = 0; j < CAPACITY; j++) perm[j] = j;
        for (int j = CAPACITY - 1; j > 0; j--) begin
            k       = $urandom_range(0, j);
            tmp     = perm[j];
            perm[j] = perm[k];
            perm[k] = tmp;
        end
        push_clear(1'b1);
        for (int j = 0; j < CAPACITY; j++) begin
            p         = KW'($urandom);
            p[IW-1:0] = perm[j][IW-1:0];
            push_pair(p, KW'($urandom), 1'b0);
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(0, seen_p.size() - 1);
                push_pair(seen_p[k], seen_t[k], 1'b0);
            end
        end
        for (int j = 0; j < 24; j++) begin
            k = $urandom_range(0, CAPACITY - 1);
            if (j % 2 == 0) push_pair(seen_p[k], ~seen_t[k], 1'b0);  // absent: full
            else push_pair(seen_p[k], seen_t[k], 1'b0);              // present: found
        end
        push_clear(1'b0);
        push_pair(16'h0000, 16'h0000, 1'b0);
        push_pair(KW'($urandom), KW'($urandom), 1'b0);

        // Hold reset, then release on a falling edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Advance until every command is taken and every result is in.
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || start || vertex_results_due.size() != 0);
        // Watch a little longer for stray strobes.
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
